FILE: rtl/pse_pkg.sv
// Package for the postfix stack evaluator: token kinds, status codes and the
// command/status structs between controller and datapath. No dependencies.
package pse_pkg;

    localparam int FIELD_W = 32;

    localparam logic [2:0] KIND_NUM = 3'd0;
    localparam logic [2:0] KIND_ADD = 3'd1;
    localparam logic [2:0] KIND_SUB = 3'd2;
    localparam logic [2:0] KIND_MUL = 3'd3;
    localparam logic [2:0] KIND_DIV = 3'd4;
    localparam logic [2:0] KIND_END = 3'd5;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_DIV_ZERO  = 3'd1;
    localparam logic [2:0] ST_BAD_OP    = 3'd2;
    localparam logic [2:0] ST_UNDERFLOW = 3'd3;
    localparam logic [2:0] ST_OVERFLOW  = 3'd4;

    typedef enum logic [1:0] {
        RES_ADD  = 2'd0,
        RES_SUB  = 2'd1,
        RES_UNIT = 2'd2
    } t_res_sel;

    typedef struct packed {
        logic       tok_load;
        logic       push;
        logic       rd_second;
        logic       ld_b;
        logic       ld_a;
        logic       wr_res;
        t_res_sel   res_sel;
        logic       unit_start;
        logic       unit_div;
        logic       clear;
        logic       out_load;
        logic       out_top;
        logic [2:0] out_status;
    } t_cmd;

    typedef struct packed {
        logic [2:0] kind;
        logic       cnt_zero;
        logic       cnt_lt2;
        logic       cnt_full;
        logic       b_zero;
        logic       unit_done;
        logic       out_free;
    } t_stat;

endpackage

FILE: rtl/pse_ifs.sv
// Token and result channel interfaces for the postfix stack evaluator.
// Depends on nothing but the fixed field widths.
interface pse_tok_if;
    logic               valid;
    logic               ready;
    logic [2:0]         kind;
    logic signed [31:0] number_value;

    modport source (output valid, output kind, output number_value, input ready);
    modport sink   (input valid, input kind, input number_value, output ready);
endinterface

interface pse_res_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] result_value;
    logic [2:0]         status;

    modport source (output valid, output result_value, output status, input ready);
    modport sink   (input valid, input result_value, input status, output ready);
endinterface

FILE: rtl/pse_muldiv.sv
// Shared iterative unit: shift-add multiply and restoring signed divide,
// one bit per cycle. Uses no package items.
module pse_muldiv #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_div,
    input  logic [DATA_WIDTH-1:0] i_a,
    input  logic [DATA_WIDTH-1:0] i_b,
    output logic                  o_done,
    output logic [DATA_WIDTH-1:0] o_result
);
    localparam int SW = $clog2(DATA_WIDTH);

    logic                  r_busy;
    logic                  r_done;
    logic [SW-1:0]         r_step;
    logic                  r_div;
    logic                  r_neg;
    logic [DATA_WIDTH-1:0] r_acc;
    logic [DATA_WIDTH-1:0] r_q;
    logic [DATA_WIDTH-1:0] r_d;

    logic [DATA_WIDTH:0]   w_rem_sh;
    logic [DATA_WIDTH:0]   w_diff;
    logic                  w_ge;
    logic [DATA_WIDTH-1:0] w_a_mag;
    logic [DATA_WIDTH-1:0] w_b_mag;

    assign w_a_mag  = i_a[DATA_WIDTH-1] ? (~i_a + 1'b1) : i_a;
    assign w_b_mag  = i_b[DATA_WIDTH-1] ? (~i_b + 1'b1) : i_b;
    assign w_rem_sh = {r_acc, r_q[DATA_WIDTH-1]};
    assign w_diff   = w_rem_sh - {1'b0, r_d};
    assign w_ge     = ~w_diff[DATA_WIDTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == SW'(DATA_WIDTH - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div <= i_div;
            r_neg <= i_a[DATA_WIDTH-1] ^ i_b[DATA_WIDTH-1];
            r_acc <= '0;
            r_q   <= i_div ? w_a_mag : i_b;
            r_d   <= i_div ? w_b_mag : i_a;
        end else if (r_busy) begin
            if (r_div) begin
                if (w_ge) begin
                    r_acc <= w_diff[DATA_WIDTH-1:0];
                end else begin
                    r_acc <= w_rem_sh[DATA_WIDTH-1:0];
                end
                r_q <= {r_q[DATA_WIDTH-2:0], w_ge};
            end else begin
                if (r_q[0]) begin
                    r_acc <= r_acc + r_d;
                end
                r_d <= r_d << 1;
                r_q <= r_q >> 1;
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_div ? (r_neg ? (~r_q + 1'b1) : r_q) : r_acc;

endmodule

FILE: rtl/pse_datapath.sv
// Datapath: token register, operand stack memory, operand registers, ALU,
// output register. Depends on pse_pkg and pse_muldiv.
module pse_datapath #(
    parameter int STACK_DEPTH = 16,
    parameter int DATA_WIDTH  = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  pse_pkg::t_cmd                      i_cmd,
    output pse_pkg::t_stat                     o_stat,
    input  logic [2:0]                         i_kind,
    input  logic [pse_pkg::FIELD_W-1:0]        i_number_value,
    output logic                               o_res_valid,
    input  logic                               i_res_ready,
    output logic [pse_pkg::FIELD_W-1:0]        o_result_value,
    output logic [2:0]                         o_status
);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int FW = pse_pkg::FIELD_W;

    logic [DATA_WIDTH-1:0] r_mem [STACK_DEPTH];
    logic [DATA_WIDTH-1:0] r_rdata;
    logic [CW-1:0]         r_cnt;
    logic [2:0]            r_kind;
    logic [DATA_WIDTH-1:0] r_num;
    logic [DATA_WIDTH-1:0] r_a;
    logic [DATA_WIDTH-1:0] r_b;
    logic                  r_out_valid;
    logic [FW-1:0]         r_out_value;
    logic [2:0]            r_out_status;

    logic [DATA_WIDTH-1:0] w_num_ext;
    logic [FW-1:0]         w_top_ext;
    logic [AW-1:0]         w_rd_addr;
    logic [AW-1:0]         w_wr_addr;
    logic [DATA_WIDTH-1:0] w_wr_data;
    logic [DATA_WIDTH-1:0] w_alu;
    logic [DATA_WIDTH-1:0] w_unit_res;
    logic                  w_unit_done;

    generate
        if (DATA_WIDTH >= FW) begin : g_wide
            assign w_num_ext = {{(DATA_WIDTH - FW + 1){i_number_value[FW-1]}},
                                i_number_value[FW-2:0]};
            assign w_top_ext = r_rdata[FW-1:0];
        end else begin : g_narrow
            assign w_num_ext = i_number_value[DATA_WIDTH-1:0];
            assign w_top_ext = {{(FW - DATA_WIDTH){r_rdata[DATA_WIDTH-1]}}, r_rdata};
        end
    endgenerate

    pse_muldiv #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_muldiv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd.unit_start),
        .i_div    (i_cmd.unit_div),
        .i_a      (r_a),
        .i_b      (r_b),
        .o_done   (w_unit_done),
        .o_result (w_unit_res)
    );

    always_comb begin
        unique case (i_cmd.res_sel)
            pse_pkg::RES_ADD: w_alu = r_a + r_b;
            pse_pkg::RES_SUB: w_alu = r_a - r_b;
            pse_pkg::RES_UNIT: w_alu = w_unit_res;
            default: w_alu = w_unit_res;
        endcase
    end

    assign w_rd_addr = i_cmd.rd_second ? AW'(r_cnt - CW'(2)) : AW'(r_cnt - CW'(1));
    assign w_wr_addr = i_cmd.push ? AW'(r_cnt) : AW'(r_cnt - CW'(2));
    assign w_wr_data = i_cmd.push ? r_num : w_alu;

    always_ff @(posedge i_clk) begin
        if (i_cmd.push || i_cmd.wr_res) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        r_rdata <= r_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.tok_load) begin
            r_kind <= i_kind;
            r_num  <= w_num_ext;
        end
        if (i_cmd.ld_b) begin
            r_b <= r_rdata;
        end
        if (i_cmd.ld_a) begin
            r_a <= r_rdata;
        end
        if (i_cmd.out_load) begin
            r_out_value  <= i_cmd.out_top ? w_top_ext : '0;
            r_out_status <= i_cmd.out_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_cnt <= '0;
            end else if (i_cmd.push) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_cmd.wr_res) begin
                r_cnt <= r_cnt - 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.kind      = r_kind;
    assign o_stat.cnt_zero  = (r_cnt == '0);
    assign o_stat.cnt_lt2   = (r_cnt < CW'(2));
    assign o_stat.cnt_full  = (r_cnt == CW'(STACK_DEPTH));
    assign o_stat.b_zero    = (r_b == '0);
    assign o_stat.unit_done = w_unit_done;
    assign o_stat.out_free  = ~r_out_valid | i_res_ready;

    assign o_res_valid    = r_out_valid;
    assign o_result_value = r_out_value;
    assign o_status       = r_out_status;

endmodule

FILE: rtl/pse_ctrl.sv
// Controller state machine: sequences decode, stack reads, arithmetic and
// result output. Depends on pse_pkg.
module pse_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_tok_valid,
    output logic           o_tok_ready,
    input  pse_pkg::t_stat i_stat,
    output pse_pkg::t_cmd  o_cmd
);
    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_DECODE  = 7'b0000010,
        S_RD_A    = 7'b0000100,
        S_LD_A    = 7'b0001000,
        S_EXEC    = 7'b0010000,
        S_WAIT    = 7'b0100000,
        S_END_OUT = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_tok_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_tok_valid) begin
                    o_cmd.tok_load = 1'b1;
                    n_state        = S_DECODE;
                end
            end
            S_DECODE: begin
                priority if (i_stat.kind == pse_pkg::KIND_NUM) begin
                    if (!i_stat.cnt_full) begin
                        o_cmd.push = 1'b1;
                        n_state    = S_IDLE;
                    end else if (i_stat.out_free) begin
                        o_cmd.out_load   = 1'b1;
                        o_cmd.out_status = pse_pkg::ST_OVERFLOW;
                        o_cmd.clear      = 1'b1;
                        n_state          = S_IDLE;
                    end
                end else if (i_stat.kind == pse_pkg::KIND_END) begin
                    if (!i_stat.cnt_zero) begin
                        n_state = S_END_OUT;
                    end else if (i_stat.out_free) begin
                        o_cmd.out_load   = 1'b1;
                        o_cmd.out_status = pse_pkg::ST_UNDERFLOW;
                        o_cmd.clear      = 1'b1;
                        n_state          = S_IDLE;
                    end
                end else if (i_stat.cnt_lt2) begin
                    if (i_stat.out_free) begin
                        o_cmd.out_load   = 1'b1;
                        o_cmd.out_status = pse_pkg::ST_UNDERFLOW;
                        o_cmd.clear      = 1'b1;
                        n_state          = S_IDLE;
                    end
                end else if (i_stat.kind > pse_pkg::KIND_END) begin
                    if (i_stat.out_free) begin
                        o_cmd.out_load   = 1'b1;
                        o_cmd.out_status = pse_pkg::ST_BAD_OP;
                        o_cmd.clear      = 1'b1;
                        n_state          = S_IDLE;
                    end
                end else begin
                    n_state = S_RD_A;
                end
            end
            S_RD_A: begin
                o_cmd.rd_second = 1'b1;
                o_cmd.ld_b      = 1'b1;
                n_state         = S_LD_A;
            end
            S_LD_A: begin
                o_cmd.ld_a = 1'b1;
                n_state    = S_EXEC;
            end
            S_EXEC: begin
                priority if (i_stat.kind == pse_pkg::KIND_ADD) begin
                    o_cmd.res_sel = pse_pkg::RES_ADD;
                    o_cmd.wr_res  = 1'b1;
                    n_state       = S_IDLE;
                end else if (i_stat.kind == pse_pkg::KIND_SUB) begin
                    o_cmd.res_sel = pse_pkg::RES_SUB;
                    o_cmd.wr_res  = 1'b1;
                    n_state       = S_IDLE;
                end else if (i_stat.kind == pse_pkg::KIND_DIV && i_stat.b_zero) begin
                    if (i_stat.out_free) begin
                        o_cmd.out_load   = 1'b1;
                        o_cmd.out_status = pse_pkg::ST_DIV_ZERO;
                        o_cmd.clear      = 1'b1;
                        n_state          = S_IDLE;
                    end
                end else begin
                    o_cmd.unit_start = 1'b1;
                    o_cmd.unit_div   = (i_stat.kind == pse_pkg::KIND_DIV);
                    n_state          = S_WAIT;
                end
            end
            S_WAIT: begin
                o_cmd.res_sel = pse_pkg::RES_UNIT;
                if (i_stat.unit_done) begin
                    o_cmd.wr_res = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_END_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_top    = 1'b1;
                    o_cmd.out_status = pse_pkg::ST_OK;
                    o_cmd.clear      = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/postfix_stack_evaluator.sv
// Top level of the postfix stack evaluator: controller plus datapath.
// Depends on pse_pkg, pse_ifs, pse_ctrl, pse_datapath, pse_muldiv.
//
//   channel  direction  fields                       transfer when
//   i_tok    in         kind[2:0], number_value[31:0] valid && ready
//   o_res    out        result_value[31:0], status[2:0] valid && ready
//
// Multiply and divide run through the shared one-bit-per-cycle
// multiply/divide unit and so take the longest of all tokens.
// One token is in work at a time.
// Reset clears the stack count, the controller and the output valid flag.
// A result waits in the output register; the next token is accepted while
// it waits, and only a second result stalls until the first is taken.
module postfix_stack_evaluator #(
    parameter int STACK_DEPTH = 16,
    parameter int DATA_WIDTH  = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pse_tok_if.sink   i_tok,
    pse_res_if.source o_res
);
    pse_pkg::t_cmd  w_cmd;
    pse_pkg::t_stat w_stat;

    pse_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_valid (i_tok.valid),
        .o_tok_ready (i_tok.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    pse_datapath #(
        .STACK_DEPTH (STACK_DEPTH),
        .DATA_WIDTH  (DATA_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_kind         (i_tok.kind),
        .i_number_value (i_tok.number_value),
        .o_res_valid    (o_res.valid),
        .i_res_ready    (o_res.ready),
        .o_result_value (o_res.result_value),
        .o_status       (o_res.status)
    );

endmodule

FILE: rtl/pse_checker.sv
// Port-level checker for the postfix stack evaluator, bound to the top.
// Depends on pse_pkg.
module pse_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_tok_valid,
    input logic        i_tok_ready,
    input logic        i_res_valid,
    input logic        i_res_ready,
    input logic [31:0] i_result_value,
    input logic [2:0]  i_status
);
    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !i_res_valid)
        else $error("result valid after reset");

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=>
            i_res_valid && $stable(i_result_value) && $stable(i_status))
        else $error("stalled result changed");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_status != pse_pkg::ST_OK |-> i_result_value == '0)
        else $error("error result with nonzero value");

    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_tok_valid && i_tok_ready |=> !i_tok_ready)
        else $error("token accepted on back-to-back cycles");
endmodule

bind postfix_stack_evaluator pse_checker u_pse_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_tok_valid    (i_tok.valid),
    .i_tok_ready    (i_tok.ready),
    .i_res_valid    (o_res.valid),
    .i_res_ready    (o_res.ready),
    .i_result_value (o_res.result_value),
    .i_status       (o_res.status)
);

FILE: sim/postfix_stack_evaluator_test.sv
// Self-checking testbench for postfix_stack_evaluator: directed tokens, then a
// random stream, idle gaps on both channels, checked by an internal stack predictor.
// Depends on pse_pkg, pse_ifs and the evaluator RTL.
`timescale 1ns / 1ps

module postfix_stack_evaluator_test;

    localparam int          STACK_DEPTH  = 16;
    localparam int          RANDOM_ITEMS = 2000;
    localparam int          CYCLE_LIMIT  = 1_000_000;
    localparam int          TAIL_CYCLES  = 60;
    localparam int          REPORT_MAX   = 10;
    localparam logic [2:0]  KIND_BAD     = 3'd6;
    localparam logic [2:0]  KIND_SPARE   = 3'd7;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] operand;
        logic        drain;
    } t_token;

    typedef struct packed {
        logic [31:0] value;
        logic [2:0]  status;
    } t_outcome;

    logic i_clk;
    logic i_rst_n;

    pse_tok_if tok ();
    pse_res_if res ();

    postfix_stack_evaluator #(
        .STACK_DEPTH(STACK_DEPTH),
        .DATA_WIDTH (32)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_tok  (tok),
        .o_res  (res)
    );

    t_token      pending_tokens[$];
    t_outcome    expected_outcomes[$];
    logic [31:0] calc_stack[STACK_DEPTH];
    int          calc_depth;
    int          deepest;
    int          total_tokens;
    int          tokens_accepted;
    int          results_checked;
    int          status_hits[5];
    int          mismatches;
    int          cycle_count;
    int          gap_left;
    int          stall_left;
    int          tx_calm;
    int          rx_calm;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Stack predictor: returns 1 when the token produces a result.
    function automatic logic predict_token(input logic [2:0] kind, input logic [31:0] operand,
                                           output t_outcome outcome);
        logic [31:0] lhs, rhs, mag_l, mag_r, quot, value;
        outcome.value  = '0;
        outcome.status = pse_pkg::ST_OK;
        if (kind == pse_pkg::KIND_NUM) begin
            if (calc_depth >= STACK_DEPTH) begin
                calc_depth     = 0;
                outcome.status = pse_pkg::ST_OVERFLOW;
                return 1'b1;
            end
            calc_stack[calc_depth] = operand;
            calc_depth++;
            if (calc_depth > deepest)
                deepest = calc_depth;
            return 1'b0;
        end
        if (kind == pse_pkg::KIND_END) begin
            if (calc_depth == 0) begin
                outcome.status = pse_pkg::ST_UNDERFLOW;
                return 1'b1;
            end
            outcome.value = calc_stack[calc_depth - 1];
            calc_depth    = 0;
            return 1'b1;
        end
        if (calc_depth < 2) begin
            calc_depth     = 0;
            outcome.status = pse_pkg::ST_UNDERFLOW;
            return 1'b1;
        end
        if (kind > pse_pkg::KIND_END) begin
            calc_depth     = 0;
            outcome.status = pse_pkg::ST_BAD_OP;
            return 1'b1;
        end
        rhs = calc_stack[calc_depth - 1];
        lhs = calc_stack[calc_depth - 2];
        case (kind)
            pse_pkg::KIND_ADD: value = lhs + rhs;
            pse_pkg::KIND_SUB: value = lhs - rhs;
            pse_pkg::KIND_MUL: value = lhs * rhs;
            default: begin
                if (rhs == '0) begin
                    calc_depth     = 0;
                    outcome.status = pse_pkg::ST_DIV_ZERO;
                    return 1'b1;
                end
                // truncate toward zero on magnitudes; min / -1 wraps to min
                mag_l = lhs[31] ? -lhs : lhs;
                mag_r = rhs[31] ? -rhs : rhs;
                quot  = mag_l / mag_r;
                value = (lhs[31] ^ rhs[31]) ? -quot : quot;
            end
        endcase
        calc_depth--;
        calc_stack[calc_depth - 1] = value;
        return 1'b0;
    endfunction

    function automatic int pick_idle(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r == 0) begin
            calm = $urandom_range(40, 120);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 19))
            0:       return 32'h0000_0000;
            1:       return 32'h0000_0001;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h8000_0000;
            4:       return 32'h7FFF_FFFF;
            5, 6, 7, 8: return 32'($urandom_range(0, 40)) - 32'd20;
            default: return $urandom();
        endcase
    endfunction

    function automatic void queue_token(input logic [2:0] kind, input logic [31:0] operand,
                                        input logic drain = 1'b0);
        t_token t;
        t.kind    = kind;
        t.operand = operand;
        t.drain   = drain;
        pending_tokens.push_back(t);
    endfunction

    // Well-formed expression; deep ones push up to a full stack before reducing.
    function automatic void queue_expression(input int operands, input logic deep,
                                             input logic drain);
        int   depth;
        int   pushed;
        logic want_op;
        depth  = 0;
        pushed = 0;
        while (pushed < operands || depth > 1) begin
            want_op = depth >= 2 &&
                      (pushed == operands || depth == STACK_DEPTH ||
                       (!(deep && pushed < STACK_DEPTH) && $urandom_range(0, 2) == 0));
            if (want_op) begin
                queue_token(3'(pse_pkg::KIND_ADD + $urandom_range(0, 3)), $urandom(), drain);
                depth--;
            end else begin
                queue_token(pse_pkg::KIND_NUM, rand_operand(), drain);
                depth++;
                pushed++;
            end
            drain = 1'b0;
        end
        queue_token(pse_pkg::KIND_END, $urandom());
    endfunction

    function automatic void note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("MISMATCH: %s", msg);
    endfunction

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d of %0d tokens accepted",
                     cycle_count, tokens_accepted, total_tokens);
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge i_clk) begin : tok_driver
        t_outcome outcome;
        t_token   next_tok;
        logic     held;
        if (!i_rst_n) begin
            tok.valid        <= 1'b0;
            tok.kind         <= pse_pkg::KIND_NUM;
            tok.number_value <= '0;
            gap_left = 0;
        end else begin
            if (tok.valid && tok.ready) begin
                if (predict_token(tok.kind, tok.number_value, outcome))
                    expected_outcomes.push_back(outcome);
                tokens_accepted++;
            end
            held = tok.valid && !tok.ready;
            if (!held) begin
                if (gap_left != 0) begin
                    gap_left--;
                    tok.valid <= 1'b0;
                end else if (pending_tokens.size() != 0 &&
                             !(pending_tokens[0].drain && expected_outcomes.size() != 0)) begin
                    next_tok = pending_tokens.pop_front();
                    tok.valid        <= 1'b1;
                    tok.kind         <= next_tok.kind;
                    tok.number_value <= next_tok.operand;
                    gap_left = pick_idle(tx_calm);
                end else begin
                    tok.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : res_monitor
        t_outcome want;
        if (!i_rst_n) begin
            res.ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (res.valid && res.ready) begin
                results_checked++;
                if (res.status <= pse_pkg::ST_OVERFLOW)
                    status_hits[res.status]++;
                if (expected_outcomes.size() == 0) begin
                    note_mismatch($sformatf("unexpected result value %0d status %0d",
                                            res.result_value, res.status));
                end else begin
                    want = expected_outcomes.pop_front();
                    if (res.result_value !== want.value)
                        note_mismatch($sformatf("result %0d: result_value expected %0d, got %0d",
                                                results_checked, $signed(want.value),
                                                res.result_value));
                    if (res.status !== want.status)
                        note_mismatch($sformatf("result %0d: status expected %0d, got %0d",
                                                results_checked, want.status, res.status));
                end
            end
            if (stall_left != 0) begin
                stall_left--;
                res.ready <= 1'b0;
            end else begin
                if ($urandom_range(0, 3) == 0)
                    stall_left = pick_idle(rx_calm);
                res.ready <= (stall_left == 0);
            end
        end
    end

    initial begin : stimulus
        int directed_count;
        int r;
        int i;
        logic first_random;
        tok.valid        = 1'b0;
        tok.kind         = pse_pkg::KIND_NUM;
        tok.number_value = '0;
        res.ready        = 1'b0;
        i_rst_n          = 1'b0;
        calc_depth       = 0;
        deepest          = 0;
        tokens_accepted  = 0;
        results_checked  = 0;
        mismatches       = 0;
        cycle_count      = 0;
        gap_left         = 0;
        stall_left       = 0;
        tx_calm          = 0;
        rx_calm          = 0;
        foreach (status_hits[k])
            status_hits[k] = 0;
        foreach (calc_stack[k])
            calc_stack[k] = '0;

        // end on empty stack, operator on a single entry
        queue_token(pse_pkg::KIND_END, $urandom());
        queue_token(pse_pkg::KIND_NUM, 32'd5);
        queue_token(pse_pkg::KIND_MUL, $urandom());
        // wrap on add, most negative divided by minus one
        queue_token(pse_pkg::KIND_NUM, 32'h7FFF_FFFF);
        queue_token(pse_pkg::KIND_NUM, 32'h0000_0001);
        queue_token(pse_pkg::KIND_ADD, $urandom());
        queue_token(pse_pkg::KIND_END, $urandom());
        queue_token(pse_pkg::KIND_NUM, 32'h8000_0000);
        queue_token(pse_pkg::KIND_NUM, 32'hFFFF_FFFF);
        queue_token(pse_pkg::KIND_DIV, $urandom());
        queue_token(pse_pkg::KIND_END, $urandom());
        // zero divisor, truncation toward zero, then subtract and multiply
        queue_token(pse_pkg::KIND_NUM, 32'd7);
        queue_token(pse_pkg::KIND_NUM, 32'd0);
        queue_token(pse_pkg::KIND_DIV, $urandom());
        queue_token(pse_pkg::KIND_NUM, -32'sd7);
        queue_token(pse_pkg::KIND_NUM, 32'd2);
        queue_token(pse_pkg::KIND_DIV, $urandom());
        queue_token(pse_pkg::KIND_END, $urandom());
        queue_token(pse_pkg::KIND_NUM, 32'd3);
        queue_token(pse_pkg::KIND_NUM, 32'd5);
        queue_token(pse_pkg::KIND_SUB, $urandom());
        queue_token(pse_pkg::KIND_NUM, -32'sd4);
        queue_token(pse_pkg::KIND_MUL, $urandom());
        queue_token(pse_pkg::KIND_END, $urandom());
        // invalid operators with two entries
        queue_token(pse_pkg::KIND_NUM, 32'd6);
        queue_token(pse_pkg::KIND_NUM, 32'd9);
        queue_token(KIND_BAD, $urandom());
        queue_token(pse_pkg::KIND_NUM, 32'd1);
        queue_token(pse_pkg::KIND_NUM, 32'd2);
        queue_token(KIND_SPARE, $urandom());
        directed_count = pending_tokens.size();

        first_random = 1'b1;
        while (pending_tokens.size() - directed_count < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 72) begin
                queue_expression($urandom_range(1, 5), 1'b0,
                                 first_random || $urandom_range(0, 99) == 0);
            end else if (r < 80) begin
                queue_expression($urandom_range(STACK_DEPTH, STACK_DEPTH + 4), 1'b1, 1'b0);
            end else if (r < 88) begin
                // one push past a full stack
                for (i = 0; i <= STACK_DEPTH; i++)
                    queue_token(pse_pkg::KIND_NUM, rand_operand());
            end else begin
                for (i = $urandom_range(1, 6); i > 0; i--)
                    queue_token(3'($urandom_range(0, 7)), rand_operand());
            end
            first_random = 1'b0;
        end
        total_tokens = pending_tokens.size();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (tokens_accepted < total_tokens || expected_outcomes.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (expected_outcomes.size() != 0)
            note_mismatch($sformatf("%0d results never arrived", expected_outcomes.size()));

        $display("Covered %0d tokens and %0d results, stack depth reached %0d of %0d",
                 tokens_accepted, results_checked, deepest, STACK_DEPTH);
        $display("Statuses seen: ok %0d, div zero %0d, bad op %0d, underflow %0d, overflow %0d",
                 status_hits[pse_pkg::ST_OK], status_hits[pse_pkg::ST_DIV_ZERO],
                 status_hits[pse_pkg::ST_BAD_OP], status_hits[pse_pkg::ST_UNDERFLOW],
                 status_hits[pse_pkg::ST_OVERFLOW]);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
